// ===== hw/rtl/one_wire_backlight_serializer_top_assert.svh =====
// assertion macros for the one-wire backlight serializer checker
`ifndef ONE_WIRE_BACKLIGHT_SERIALIZER_TOP_ASSERT_SVH
`define ONE_WIRE_BACKLIGHT_SERIALIZER_TOP_ASSERT_SVH

// implication checked in the same cycle, off during reset
`define OWBS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("owbs check failed");

// implication checked in the following cycle, off during reset
`define OWBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("owbs check failed");

// implication checked in the following cycle, also across reset
`define OWBS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("owbs check failed");

`endif

// ===== hw/rtl/owbs_pkg.sv =====
// shared types and constants of the one-wire backlight serializer
package owbs_pkg;

  localparam int DataWidth   = 8;
  localparam int TickWidth   = 10;
  localparam int LevelWidth  = 6;
  localparam int ByteWidth   = 5;
  localparam int IndexWidth  = 3;
  localparam int BitIdxWidth = 3;

  localparam logic [IndexWidth-1:0] REG_DEVICE_ADDRESS      = 3'd0;
  localparam logic [IndexWidth-1:0] REG_SHORT_TICKS         = 3'd1;
  localparam logic [IndexWidth-1:0] REG_LONG_TICKS          = 3'd2;
  localparam logic [IndexWidth-1:0] REG_SELECT_HIGH_TICKS   = 3'd3;
  localparam logic [IndexWidth-1:0] REG_SELECT_LOW_TICKS    = 3'd4;
  localparam logic [IndexWidth-1:0] REG_SELECT_SETTLE_TICKS = 3'd5;

  localparam logic [DataWidth-1:0] RST_DEVICE_ADDRESS      = 8'h72;
  localparam logic [TickWidth-1:0] RST_SHORT_TICKS         = 10'd10;
  localparam logic [TickWidth-1:0] RST_LONG_TICKS          = 10'd180;
  localparam logic [TickWidth-1:0] RST_SELECT_HIGH_TICKS   = 10'd120;
  localparam logic [TickWidth-1:0] RST_SELECT_LOW_TICKS    = 10'd280;
  localparam logic [TickWidth-1:0] RST_SELECT_SETTLE_TICKS = 10'd650;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  localparam logic [LevelWidth-1:0]  LEVEL_MAX = 6'd32;
  localparam logic [BitIdxWidth-1:0] LAST_BIT  = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEL_HI,
    PH_SEL_LO,
    PH_SEL_SETTLE,
    PH_START,
    PH_BIT_LO,
    PH_BIT_HI,
    PH_END
  } phase_t;

  typedef struct packed {
    logic [DataWidth-1:0] device_address;
    logic [TickWidth-1:0] short_ticks;
    logic [TickWidth-1:0] long_ticks;
    logic [TickWidth-1:0] select_high_ticks;
    logic [TickWidth-1:0] select_low_ticks;
    logic [TickWidth-1:0] select_settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic                  req_type;
    logic [LevelWidth-1:0] level;
    logic                  panel_on;
  } item_t;

  typedef struct packed {
    logic mode_selected;
    logic rejected;
    logic busy_res;
    logic line_level;
  } result_t;

endpackage

// ===== hw/rtl/owbs_cfg_regs.sv =====
// configuration register file of the serializer
module owbs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [owbs_pkg::IndexWidth-1:0] cfg_index,
  input  logic [owbs_pkg::TickWidth-1:0]  cfg_data,
  output owbs_pkg::cfg_t                  cfg
);
  import owbs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address      <= RST_DEVICE_ADDRESS;
      cfg.short_ticks         <= RST_SHORT_TICKS;
      cfg.long_ticks          <= RST_LONG_TICKS;
      cfg.select_high_ticks   <= RST_SELECT_HIGH_TICKS;
      cfg.select_low_ticks    <= RST_SELECT_LOW_TICKS;
      cfg.select_settle_ticks <= RST_SELECT_SETTLE_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS:      cfg.device_address      <= cfg_data[DataWidth-1:0];
        REG_SHORT_TICKS:         cfg.short_ticks         <= cfg_data;
        REG_LONG_TICKS:          cfg.long_ticks          <= cfg_data;
        REG_SELECT_HIGH_TICKS:   cfg.select_high_ticks   <= cfg_data;
        REG_SELECT_LOW_TICKS:    cfg.select_low_ticks    <= cfg_data;
        REG_SELECT_SETTLE_TICKS: cfg.select_settle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/owbs_in_reg.sv =====
// input register stage holding one word for the sequencer
module owbs_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  owbs_pkg::item_t s_item,
  input  logic            take,
  output logic            item_valid,
  output owbs_pkg::item_t item
);
  import owbs_pkg::*;

  assign s_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

// ===== hw/rtl/owbs_core.sv =====
// pulse sequencer state and next-state logic, one step per word
module owbs_core (
  input  logic              clk,
  input  logic              rst,
  input  owbs_pkg::cfg_t    cfg,
  input  logic              step,
  input  owbs_pkg::item_t   item,
  output owbs_pkg::result_t result
);
  import owbs_pkg::*;

  phase_t                 phase, phase_next;
  logic [TickWidth-1:0]   phase_count, phase_count_next;
  logic [BitIdxWidth-1:0] bit_index, bit_index_next;
  logic                   frame_index, frame_index_next;
  logic [DataWidth-1:0]   shift_word, shift_word_next;
  logic [ByteWidth-1:0]   data_byte, data_byte_next;
  logic                   wire_mode_on, wire_mode_on_next;
  logic                   line_reg, line_reg_next;

  logic                   busy;
  logic                   rej;
  logic                   bit_one;
  logic [TickWidth-1:0]   phase_len;
  logic [TickWidth:0]     count_inc;
  logic [LevelWidth-1:0]  level_sat;

  assign busy    = (phase != PH_IDLE);
  assign bit_one = shift_word[DataWidth-1];

  always_comb begin
    unique case (phase)
      PH_SEL_HI:     phase_len = cfg.select_high_ticks;
      PH_SEL_LO:     phase_len = cfg.select_low_ticks;
      PH_SEL_SETTLE: phase_len = cfg.select_settle_ticks;
      PH_BIT_LO:     phase_len = bit_one ? cfg.short_ticks : cfg.long_ticks;
      PH_BIT_HI:     phase_len = bit_one ? cfg.long_ticks : cfg.short_ticks;
      default:       phase_len = cfg.short_ticks;
    endcase
  end

  assign count_inc = {1'b0, phase_count} + {{TickWidth{1'b0}}, 1'b1};
  assign level_sat = (item.level > LEVEL_MAX) ? LEVEL_MAX : item.level;

  always_comb begin
    phase_next        = phase;
    phase_count_next  = phase_count;
    bit_index_next    = bit_index;
    frame_index_next  = frame_index;
    shift_word_next   = shift_word;
    data_byte_next    = data_byte;
    wire_mode_on_next = wire_mode_on;
    line_reg_next     = line_reg;
    rej               = 1'b0;

    if (item.req_type == REQ_SET) begin
      if (busy) begin
        rej = 1'b1;
      end else if (!item.panel_on || item.level == '0) begin
        line_reg_next     = 1'b0;
        wire_mode_on_next = 1'b0;
      end else begin
        data_byte_next = ByteWidth'(level_sat - LevelWidth'(1));
        phase_count_next = '0;
        line_reg_next    = 1'b1;
        if (!wire_mode_on) begin
          wire_mode_on_next = 1'b1;
          phase_next        = PH_SEL_HI;
        end else begin
          frame_index_next = 1'b0;
          shift_word_next  = cfg.device_address;
          bit_index_next   = '0;
          phase_next       = PH_START;
        end
      end
    end else if (busy) begin
      if (count_inc >= {1'b0, phase_len}) begin
        phase_count_next = '0;
        unique case (phase)
          PH_SEL_HI: begin
            phase_next    = PH_SEL_LO;
            line_reg_next = 1'b0;
          end
          PH_SEL_LO: begin
            phase_next    = PH_SEL_SETTLE;
            line_reg_next = 1'b1;
          end
          PH_SEL_SETTLE: begin
            frame_index_next = 1'b0;
            shift_word_next  = cfg.device_address;
            bit_index_next   = '0;
            phase_next       = PH_START;
            line_reg_next    = 1'b1;
          end
          PH_START: begin
            phase_next    = PH_BIT_LO;
            line_reg_next = 1'b0;
          end
          PH_BIT_LO: begin
            phase_next    = PH_BIT_HI;
            line_reg_next = 1'b1;
          end
          PH_BIT_HI: begin
            shift_word_next = {shift_word[DataWidth-2:0], 1'b0};
            line_reg_next   = 1'b0;
            if (bit_index == LAST_BIT) begin
              bit_index_next = '0;
              phase_next     = PH_END;
            end else begin
              bit_index_next = bit_index + BitIdxWidth'(1);
              phase_next     = PH_BIT_LO;
            end
          end
          PH_END: begin
            line_reg_next = 1'b1;
            if (!frame_index) begin
              frame_index_next = 1'b1;
              shift_word_next  = {{(DataWidth-ByteWidth){1'b0}}, data_byte};
              bit_index_next   = '0;
              phase_next       = PH_START;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end else begin
        phase_count_next = count_inc[TickWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      phase_count  <= '0;
      bit_index    <= '0;
      frame_index  <= 1'b0;
      shift_word   <= '0;
      data_byte    <= '0;
      wire_mode_on <= 1'b1;
      line_reg     <= 1'b1;
    end else if (step) begin
      phase        <= phase_next;
      phase_count  <= phase_count_next;
      bit_index    <= bit_index_next;
      frame_index  <= frame_index_next;
      shift_word   <= shift_word_next;
      data_byte    <= data_byte_next;
      wire_mode_on <= wire_mode_on_next;
      line_reg     <= line_reg_next;
    end
  end

  assign result.line_level    = line_reg_next;
  assign result.busy_res      = (phase_next != PH_IDLE);
  assign result.rejected      = rej;
  assign result.mode_selected = wire_mode_on_next;

endmodule

// ===== hw/rtl/owbs_out_reg.sv =====
// result register on the master side
module owbs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              take,
  input  owbs_pkg::result_t result,
  output logic              m_valid,
  input  logic              m_ready,
  output owbs_pkg::result_t m_result
);
  import owbs_pkg::*;

  assign take = item_valid && (!m_valid || m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (take) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_result <= result;
    end
  end

endmodule

// ===== hw/rtl/one_wire_backlight_serializer_top.sv =====
// top level of the one-wire backlight serializer
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tdata level, panel_on; tuser req_type
//   m_*      out  m_tvalid/m_tready   tdata line_level, busy_res, rejected, mode_selected
//   cfg_*    in   cfg_we              cfg_index, cfg_data
//
// one word per cycle sustained while the result is not stalled: an input register, the
// sequencer logic, then the result register; the sequencer state loop closes through that logic
// an accepted word is held in the input register, then its result in the result register
// rst is synchronous and clears the sequencer to idle with the line high
// a stalled result holds the result register; the input register takes a new word while
// the result waits only if it is empty, and refills once the result is taken
module one_wire_backlight_serializer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // level[5:0], panel_on[6], zero[7]
  input  logic                            s_tuser,  // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,  // line_level, busy_res, rejected,
                                                    // mode_selected, zero[7:4]
  input  logic                            cfg_we,
  input  logic [owbs_pkg::IndexWidth-1:0] cfg_index,
  input  logic [owbs_pkg::TickWidth-1:0]  cfg_data
);
  import owbs_pkg::*;

  cfg_t    cfg;
  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t result;
  result_t m_result;

  assign s_item.req_type = s_tuser;
  assign s_item.level    = s_tdata[LevelWidth-1:0];
  assign s_item.panel_on = s_tdata[LevelWidth];

  owbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owbs_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  owbs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (take),
    .item   (item),
    .result (result)
  );

  owbs_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .take       (take),
    .result     (result),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_result   (m_result)
  );

  assign m_tdata = {4'b0000, m_result};

endmodule

// ===== hw/rtl/owbs_checker.sv =====
// port-level checker of the serializer and its bind
`include "one_wire_backlight_serializer_top_assert.svh"

module owbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled result word holds
  `OWBS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // input only waits behind a stalled result word
  `OWBS_ASSERT_SAME(a_in_wait, s_tvalid && !s_tready, m_tvalid && !m_tready)

  // a refused request only happens during a transfer
  `OWBS_ASSERT_SAME(a_reject_busy, m_tvalid && m_tdata[2], m_tdata[1])

  // with one-wire mode cleared the line sits low and nothing is in flight
  `OWBS_ASSERT_SAME(a_mode_off_low, m_tvalid && !m_tdata[3], !m_tdata[0] && !m_tdata[1])

  // no result word right after reset
  `OWBS_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid)

endmodule

bind one_wire_backlight_serializer_top owbs_checker u_owbs_checker (.*);
